@@ src/cdmb_pkg.sv @@
// Shared types and codes for the capture-then-drain message buffer.
// No dependencies; imported by the core.
package cdmb_pkg;

	localparam int OPCODE_W = 2;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 7;

	localparam logic [OPCODE_W-1:0] OP_BEGIN = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_END   = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_DRAIN = 2'd3;

	// Largest number of bytes one drain item may move.
	localparam logic [COUNT_W-1:0] DRAIN_CAP = 7'd64;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [BYTE_W-1:0]   data_byte;
		logic [COUNT_W-1:0]  tx_room;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic                byte_valid;
		logic [BYTE_W-1:0]   tx_byte;
		logic [COUNT_W-1:0]  sent_count;
		logic                idle_flag;
		logic                capturing_flag;
		logic                last;
	} rsp_t;

endpackage

@@ src/cdmb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/capture_then_drain_message_buffer_core.sv @@
// Capture-then-drain message buffer core: records a report byte by byte, then drains it.
// Depends on cdmb_pkg (item types, opcodes) and cdmb_ram (byte store).
//
// Usage:
//   req channel (req_valid / req_stall / req) carries commands: begin, put byte, end, drain.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one item per command, or one item per
//   drained byte; rsp.last marks the final item of a command.
// Command and drain flow:
//   Begin, put and end each give one item; it shows on rsp the cycle after accept.
//   A drain of n bytes holds req_stall high until its last byte enters the output register;
//   each byte is read at the read position into the RAM output register, then moves on, so
//   bytes leave at one per cycle while rsp_stall is low. An empty drain gets a single item.
//   A command is accepted while the previous item still waits, if it is being taken.
// Reset:
//   arst_n clears length, read position, capture and overflow flags and empties the output.
//   The byte store is not cleared; only bytes written by the current capture are read.
// Receiver stall:
//   rsp holds while rsp_stall is high; during a drain the store read pauses and the fetched
//   byte waits at the RAM output, so no byte is lost or repeated.
module capture_then_drain_message_buffer_core
	import cdmb_pkg::*;
#(
	parameter int CAPACITY     = 256,
	parameter int DRAIN_BUDGET = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int LEN_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W  = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;
	localparam logic [LEN_W-1:0]   CAP_LEN = LEN_W'(CAPACITY);
	localparam logic [COUNT_W-1:0] BUDGET  = COUNT_W'(DRAIN_BUDGET);

	typedef enum logic {
		ST_CMD,
		ST_DRAIN
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   rp_q;
	logic               cap_q;
	logic               ovf_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic [COUNT_W-1:0] iss_left_q;
	logic [COUNT_W-1:0] sent_q;
	logic [COUNT_W-1:0] n_q;
	logic               drain_idle_q;
	logic               pend_s2;

	logic               out_free;
	logic               accept;
	logic               idle_now;
	logic [LEN_W-1:0]   rem;
	logic [CMP_W-1:0]   rem_w;
	logic [COUNT_W-1:0] lim;
	logic [COUNT_W-1:0] drain_n;
	logic               drain_start;
	logic               wr_en;
	logic               cmd_ok;
	logic [LEN_W-1:0]   nxt_len;
	logic [LEN_W-1:0]   nxt_rp;
	logic               nxt_cap;
	logic               nxt_ovf;
	logic               cmd_idle;
	logic               rd_en;
	logic [BYTE_W-1:0]  rd_data;
	logic               load_byte;
	logic [COUNT_W-1:0] sent_nxt;
	logic               byte_last;
	logic               rsp_load;

	// The output register frees up when empty or when its item is taken this cycle.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_CMD) || !out_free;
	assign accept    = req_valid && !req_stall;

	assign idle_now = !cap_q && (rp_q == len_q);
	assign rem      = len_q - rp_q;
	assign rem_w    = CMP_W'(rem);

	// Clamp the drain to budget, transmitter room, the per-item maximum and the bytes left; none while capturing.
	always_comb begin
		lim = (BUDGET < req.tx_room) ? BUDGET : req.tx_room;
		if (lim > DRAIN_CAP) begin
			lim = DRAIN_CAP;
		end
		if (cap_q) begin
			drain_n = '0;
		end else if (rem_w < CMP_W'(lim)) begin
			drain_n = COUNT_W'(rem_w);
		end else begin
			drain_n = lim;
		end
	end

	assign drain_start = accept && (req.opcode == OP_DRAIN) && (drain_n != '0);

	// Decode begin / put / end into next control state.
	always_comb begin
		nxt_len = len_q;
		nxt_rp  = rp_q;
		nxt_cap = cap_q;
		nxt_ovf = ovf_q;
		cmd_ok  = 1'b0;
		wr_en   = 1'b0;
		unique case (req.opcode)
			OP_BEGIN: begin
				if (idle_now) begin
					nxt_len = '0;
					nxt_rp  = '0;
					nxt_ovf = 1'b0;
					nxt_cap = 1'b1;
					cmd_ok  = 1'b1;
				end
			end
			OP_PUT: begin
				if (cap_q && !ovf_q) begin
					if (len_q >= CAP_LEN) begin
						nxt_ovf = 1'b1;
					end else begin
						wr_en   = 1'b1;
						nxt_len = len_q + LEN_W'(1);
					end
				end
			end
			OP_END: begin
				if (cap_q) begin
					nxt_cap = 1'b0;
					if (ovf_q) begin
						nxt_len = '0;
						nxt_rp  = '0;
					end else begin
						cmd_ok = 1'b1;
					end
				end
			end
			OP_DRAIN: begin
			end
		endcase
	end

	assign cmd_idle = !nxt_cap && (nxt_rp == nxt_len);

	// Fetch the next byte when no byte waits at the RAM output, or when the waiting one moves on this cycle.
	assign rd_en     = (state_q == ST_DRAIN) && (iss_left_q != '0) && (!pend_s2 || out_free);
	assign load_byte = (state_q == ST_DRAIN) && pend_s2 && out_free;
	assign sent_nxt  = sent_q + COUNT_W'(1);
	assign byte_last = (sent_nxt == n_q);

	// A command answer or a drained byte enters the output register.
	assign rsp_load  = (accept && !drain_start) || load_byte;

	cdmb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (len_q[ADDR_W-1:0]),
		.wdata (req.data_byte),
		.re    (rd_en),
		.raddr (rp_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CMD;
			len_q        <= '0;
			rp_q         <= '0;
			cap_q        <= 1'b0;
			ovf_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			iss_left_q   <= '0;
			sent_q       <= '0;
			n_q          <= '0;
			drain_idle_q <= 1'b0;
			pend_s2      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CMD: begin
					if (drain_start) begin
						state_q      <= ST_DRAIN;
						n_q          <= drain_n;
						iss_left_q   <= drain_n;
						sent_q       <= '0;
						drain_idle_q <= (CMP_W'(drain_n) == rem_w);
					end else if (accept) begin
						len_q                <= nxt_len;
						rp_q                 <= nxt_rp;
						cap_q                <= nxt_cap;
						ovf_q                <= nxt_ovf;
						rsp_q.ok             <= cmd_ok;
						rsp_q.byte_valid     <= 1'b0;
						rsp_q.tx_byte        <= '0;
						rsp_q.sent_count     <= '0;
						rsp_q.idle_flag      <= cmd_idle;
						rsp_q.capturing_flag <= nxt_cap;
						rsp_q.last           <= 1'b1;
					end
				end
				ST_DRAIN: begin
					// Advance the read position as each byte is fetched.
					if (rd_en) begin
						rp_q       <= rp_q + LEN_W'(1);
						iss_left_q <= iss_left_q - COUNT_W'(1);
					end
					if (load_byte) begin
						sent_q               <= sent_nxt;
						rsp_q.ok             <= 1'b0;
						rsp_q.byte_valid     <= 1'b1;
						rsp_q.tx_byte        <= rd_data;
						rsp_q.sent_count     <= sent_nxt;
						rsp_q.idle_flag      <= byte_last && drain_idle_q;
						rsp_q.capturing_flag <= 1'b0;
						rsp_q.last           <= byte_last;
						if (byte_last) begin
							state_q <= ST_CMD;
						end
					end
				end
				default: begin
					state_q <= ST_CMD;
				end
			endcase
			// Hold the output item while stalled; drop it once taken unless a new one loads.
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			pend_s2     <= rd_en || (pend_s2 && !out_free);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The read position never passes the stored length.
	a_rp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= len_q)
		else $error("read position beyond stored length");

	// The store is only read for a closed capture that did not overflow.
	a_read_closed: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (!cap_q && !ovf_q))
		else $error("store read during capture or after overflow");

	// Commands are held off for the whole drain.
	a_drain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> req_stall)
		else $error("command accepted during drain");

	// The final byte of a drain carries the full count.
	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.byte_valid && rsp.last) |-> (rsp.sent_count == n_q))
		else $error("final drained byte with wrong count");

endmodule

@@ verif/capture_then_drain_message_buffer_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for capture_then_drain_message_buffer_core: directed and random command items
// are checked against a built-in predictor of the buffer. Depends on cdmb_pkg and the core.
module capture_then_drain_message_buffer_core_tb
	import cdmb_pkg::*;
();

	localparam int CAPACITY     = 256;
	localparam int DRAIN_BUDGET = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 6;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	capture_then_drain_message_buffer_core #(
		.CAPACITY     (CAPACITY),
		.DRAIN_BUDGET (DRAIN_BUDGET)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted copy of the buffer state
	logic [7:0]  msg_store [CAPACITY];
	int unsigned msg_len;
	int unsigned drain_pos;
	bit          cap_open;
	bit          overflowed;

	req_t pending_req_q[$];
	rsp_t expected_rsp_q[$];

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int pushed_count   = 0;
	int accepted_count = 0;
	int phase_items    = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;
	int result_count   = 0;
	int drain_items    = 0;
	int drained_bytes  = 0;
	int ok_count       = 0;
	logic req_taken    = 1'b0;

	function automatic bit buf_idle();
		return !cap_open && (drain_pos == msg_len);
	endfunction

	// Build one result with the status flags as seen after its action
	function automatic rsp_t status_rsp(bit ok, bit vld, logic [7:0] b, int unsigned cnt,
			bit lst);
		rsp_t r;
		r.ok             = ok;
		r.byte_valid     = vld;
		r.tx_byte        = b;
		r.sent_count     = cnt[COUNT_W-1:0];
		r.idle_flag      = buf_idle();
		r.capturing_flag = cap_open;
		r.last           = lst;
		return r;
	endfunction

	// Advance the predicted state by one command and queue the results it causes
	function automatic void predict_results(input req_t r);
		bit          ok;
		int unsigned n;
		logic [7:0]  b;
		ok = 1'b0;
		n  = 0;
		case (r.opcode)
			OP_BEGIN: begin
				if (buf_idle()) begin
					msg_len    = 0;
					drain_pos  = 0;
					overflowed = 1'b0;
					cap_open   = 1'b1;
					ok         = 1'b1;
				end
			end
			OP_PUT: begin
				if (cap_open && !overflowed) begin
					// a full store flags overflow and drops the byte
					if (msg_len >= CAPACITY) begin
						overflowed = 1'b1;
					end else begin
						msg_store[msg_len] = r.data_byte;
						msg_len++;
					end
				end
			end
			OP_END: begin
				if (cap_open) begin
					cap_open = 1'b0;
					// an overflowed message is thrown away
					if (overflowed) begin
						msg_len   = 0;
						drain_pos = 0;
					end else begin
						ok = 1'b1;
					end
				end
			end
			OP_DRAIN: begin
				if (!cap_open && drain_pos < msg_len) begin
					n = msg_len - drain_pos;
					if (n > DRAIN_BUDGET) n = DRAIN_BUDGET;
					if (n > r.tx_room) n = r.tx_room;
					if (n > DRAIN_CAP) n = DRAIN_CAP;
				end
			end
		endcase
		if (r.opcode == OP_DRAIN && n != 0) begin
			for (int unsigned k = 0; k < n; k++) begin
				b = msg_store[drain_pos];
				drain_pos++;
				expected_rsp_q.push_back(status_rsp(1'b0, 1'b1, b, k + 1, k + 1 == n));
			end
		end else begin
			expected_rsp_q.push_back(status_rsp(ok, 1'b0, 8'h00, 0, 1'b1));
		end
	endfunction

	// Compare one accepted result with the oldest expectation, field by field
	function automatic void check_result(input rsp_t got);
		rsp_t want;
		bit   bad;
		if (expected_rsp_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("[%0t] unexpected result", $realtime);
				$display("  actual:   ok=%0d vld=%0d byte=%h cnt=%0d idle=%0d cap=%0d last=%0d",
					got.ok, got.byte_valid, got.tx_byte, got.sent_count,
					got.idle_flag, got.capturing_flag, got.last);
			end
			return;
		end
		want = expected_rsp_q.pop_front();
		bad  = (got.ok !== want.ok) || (got.byte_valid !== want.byte_valid) ||
			(got.tx_byte !== want.tx_byte) || (got.sent_count !== want.sent_count) ||
			(got.idle_flag !== want.idle_flag) ||
			(got.capturing_flag !== want.capturing_flag) || (got.last !== want.last);
		if (bad) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("[%0t] result mismatch", $realtime);
				$display("  expected: ok=%0d vld=%0d byte=%h cnt=%0d idle=%0d cap=%0d last=%0d",
					want.ok, want.byte_valid, want.tx_byte, want.sent_count,
					want.idle_flag, want.capturing_flag, want.last);
				$display("  actual:   ok=%0d vld=%0d byte=%h cnt=%0d idle=%0d cap=%0d last=%0d",
					got.ok, got.byte_valid, got.tx_byte, got.sent_count,
					got.idle_flag, got.capturing_flag, got.last);
			end
		end
	endfunction

	// Sample both channels at the rising edge: check results first, then predict
	always @(posedge clk) begin
		req_taken <= req_valid && !req_stall;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				result_count++;
				if (rsp.byte_valid === 1'b1) drained_bytes++;
				if (rsp.ok === 1'b1) ok_count++;
				check_result(rsp);
			end
			if (req_valid && !req_stall) begin
				accepted_count++;
				if (req.opcode == OP_DRAIN) drain_items++;
				predict_results(req);
			end
		end
	end

	// Driver: change inputs at the falling edge; hold the item until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (pending_req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					req       <= pending_req_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, expected_rsp_q.size());
			$display("capture_then_drain_message_buffer_core_tb: FAIL");
			$finish;
		end
	end

	task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [7:0] data,
			input logic [COUNT_W-1:0] room);
		req_t r;
		r.opcode    = op;
		r.data_byte = data;
		r.tx_room   = room;
		pending_req_q.push_back(r);
		pushed_count++;
		phase_items++;
	endtask

	// Mostly modest room, with no room and the widest room now and then
	function automatic logic [COUNT_W-1:0] pick_room();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 25) return 7'd64;
		return COUNT_W'($urandom_range(1, 40));
	endfunction

	// Issue drains until the given number of bytes would have left
	task automatic drain_bytes(input int unsigned remaining);
		logic [COUNT_W-1:0] room;
		int unsigned        n;
		while (remaining > 0) begin
			room = pick_room();
			n    = remaining;
			if (n > DRAIN_BUDGET) n = DRAIN_BUDGET;
			if (n > room) n = room;
			push_item(OP_DRAIN, 8'($urandom), room);
			remaining -= n;
		end
	endtask

	// Begin, len puts, end; drain it unless it overflows the store
	task automatic push_message(input int unsigned len);
		push_item(OP_BEGIN, 8'($urandom), 7'($urandom_range(64)));
		repeat (len) push_item(OP_PUT, 8'($urandom), 7'($urandom_range(64)));
		push_item(OP_END, 8'($urandom), 7'($urandom_range(64)));
		if (len <= CAPACITY) drain_bytes(len);
	endtask

	task automatic wait_accepted();
		while (accepted_count != pushed_count) @(posedge clk);
	endtask

	// Close and empty the buffer so the next message starts from idle
	task automatic tidy_buffer();
		int unsigned left;
		wait_accepted();
		left = msg_len - drain_pos;
		if (cap_open) begin
			push_item(OP_END, 8'h00, 7'd0);
			if (overflowed) left = 0;
		end
		drain_bytes(left);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int big_len);
		int sel;
		int len;
		send_gap_pct   = send_pct;
		recv_stall_pct = recv_pct;
		tidy_buffer();
		if (big_len > 0) push_message(big_len);
		phase_items = 0;
		while (phase_items < RANDOM_ITEMS) begin
			sel = $urandom_range(99);
			if (sel < 75) begin
				push_message($urandom_range(0, 20));
			end else if (sel < 87) begin
				// noise: any command with random data and room
				push_item(2'($urandom), 8'($urandom), 7'($urandom_range(64)));
			end else begin
				// broken sequence: refused drain and begin mid-capture, begin before drained
				len = $urandom_range(1, 20);
				push_item(OP_BEGIN, 8'($urandom), 7'd0);
				repeat (len) push_item(OP_PUT, 8'($urandom), 7'd0);
				push_item(OP_DRAIN, 8'($urandom), pick_room());
				push_item(OP_BEGIN, 8'($urandom), 7'd0);
				push_item(OP_END, 8'($urandom), 7'd0);
				push_item(OP_DRAIN, 8'($urandom), 7'd1);
				push_item(OP_BEGIN, 8'($urandom), 7'd0);
				push_item(OP_END, 8'($urandom), 7'd0);
				drain_bytes(len - 1);
			end
		end
		wait_accepted();
	endtask

	initial begin
		int settle;
		msg_len    = 0;
		drain_pos  = 0;
		cap_open   = 1'b0;
		overflowed = 1'b0;
		send_gap_pct   = 18;
		recv_stall_pct = 49;

		// hold reset, then release it at a falling edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: commands out of place, then a short message drained in pieces
		push_item(OP_DRAIN, 8'h00, 7'd64);  // nothing captured yet
		push_item(OP_END, 8'h00, 7'd0);     // end with no capture open
		push_item(OP_PUT, 8'hFF, 7'd0);     // put outside a capture
		push_item(OP_BEGIN, 8'h00, 7'd0);
		push_item(OP_BEGIN, 8'h00, 7'd0);   // refused, capture open
		push_item(OP_DRAIN, 8'h00, 7'd64);  // refused while capturing
		push_item(OP_PUT, 8'h00, 7'd127 & 7'd64);
		push_item(OP_PUT, 8'hFF, 7'd0);
		push_item(OP_PUT, 8'h55, 7'd0);
		push_item(OP_PUT, 8'hAA, 7'd0);
		push_item(OP_END, 8'h00, 7'd0);
		push_item(OP_PUT, 8'h12, 7'd0);     // put after end
		push_item(OP_BEGIN, 8'h00, 7'd0);   // refused, bytes left to drain
		push_item(OP_DRAIN, 8'h00, 7'd0);   // no room
		push_item(OP_DRAIN, 8'h00, 7'd1);
		push_item(OP_DRAIN, 8'h00, 7'd64);
		push_item(OP_DRAIN, 8'h00, 7'd64);  // nothing left
		push_item(OP_BEGIN, 8'h00, 7'd0);
		push_item(OP_END, 8'h00, 7'd0);     // empty message
		push_item(OP_DRAIN, 8'h00, 7'd64);
		wait_accepted();

		// a message that fills the store and overflows it, then no idling at all
		run_phase(18, 49, 0);
		run_phase(49, 18, CAPACITY + 2);
		run_phase(0, 0, 0);

		settle = 0;
		while (expected_rsp_q.size() != 0 && settle < SETTLE_LIMIT) begin
			@(posedge clk);
			settle++;
		end
		repeat (DRAIN_BUDGET + 4) @(posedge clk);
		if (expected_rsp_q.size() != 0) begin
			mismatch_count++;
			$display("%0d expected results never arrived", expected_rsp_q.size());
		end

		$display("covered %0d command items (%0d drains), %0d results checked",
			accepted_count, drain_items, result_count);
		$display("drained %0d bytes, %0d successful begin/end, %0d mismatches",
			drained_bytes, ok_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("capture_then_drain_message_buffer_core_tb: PASS");
		end else begin
			$display("capture_then_drain_message_buffer_core_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/cdmb_pkg.sv
src/cdmb_ram.sv
src/capture_then_drain_message_buffer_core.sv
verif/capture_then_drain_message_buffer_core_tb.sv
